[hdl/totient_sieve_table_defines.svh]
// ---------------------------------------------------------------------------
// totient_sieve_table_defines.svh
// Assertion macros for the totient sieve table. The macros expect clk and
// rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef TOTIENT_SIEVE_TABLE_DEFINES_SVH
`define TOTIENT_SIEVE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TST_ASSERT_IMPL(lbl, ante, cons, msg)
`define TST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/tst_pkg.sv]
// ---------------------------------------------------------------------------
// tst_pkg
// Field widths, codes and controller states of the totient sieve table.
// ---------------------------------------------------------------------------
package tst_pkg;

    localparam int unsigned LIMIT_W       = 10;
    localparam int unsigned INDEX_W       = 10;
    localparam int unsigned VALUE_W       = 10;
    localparam int unsigned TDATA_W       = 16;
    localparam int unsigned MAX_N_DEFAULT = 1023;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MUL_RD,
        ST_MUL_LOAD,
        ST_DIV,
        ST_RESP
    } tst_state_t;

endpackage

[hdl/totient_sieve_table.sv]
// ---------------------------------------------------------------------------
// totient_sieve_table
// Table of Euler totient values built by a sieve in one block RAM.
//
// Input beats carry kind on s_tuser (0 = build, 1 = query) and the query
// index on s_tdata. Every input beat yields exactly one output beat:
// value on m_tdata, ok on m_tuser.
// A query reads one RAM word: accepted in IDLE, its result passes through
// RESP into the output register, and the next beat is taken back in IDLE.
// A build fills entries 0..top (top = limit, capped at MAX_N), then checks
// each i in 2..top with a read. For each prime i, every multiple j gets a
// read, a load and an iterative exact divide of EW steps (EW = entry
// width, 10 at the default size). The shared divider sets the build time.
// The limit register is written through cfg_wen/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears the control state and the built flag; the RAM is not
// cleared, and queries before the first build return ok = 0.
// When the receiver stalls, the result holds in the output register, one
// more beat is accepted, and its result waits until the register frees.
// ---------------------------------------------------------------------------
`include "totient_sieve_table_defines.svh"

module totient_sieve_table #(
    parameter int unsigned MAX_N = tst_pkg::MAX_N_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [tst_pkg::LIMIT_W-1:0]  cfg_wdata,  // limit
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tst_pkg::TDATA_W-1:0]  s_tdata,    // [9:0] index
    input  logic                         s_tuser,    // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tst_pkg::TDATA_W-1:0]  m_tdata,    // [9:0] value
    output logic                         m_tuser     // ok
);

    import tst_pkg::*;

    localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
    localparam int unsigned TOP_MAX   = (MAX_N < LIMIT_MAX) ? MAX_N : LIMIT_MAX;
    localparam int unsigned DEPTH     = MAX_N + 1;
    localparam int unsigned AW        = $clog2(MAX_N + 1);
    localparam int unsigned EW        = $clog2(TOP_MAX + 1);
    localparam int unsigned CW        = EW + 1;
    localparam int unsigned DW        = $clog2(EW);

    tst_state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic               built_reg, built_next;
    logic [LIMIT_W-1:0] built_limit_reg, built_limit_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [EW-1:0]      t_reg, t_next;
    logic [EW-1:0]      rem_reg, rem_next;
    logic [EW-1:0]      dvd_reg, dvd_next;
    logic [DW-1:0]      div_cnt_reg, div_cnt_next;
    logic               q_ok_reg, q_ok_next;
    logic               q_build_reg, q_build_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic               m_ok_reg, m_ok_next;

    logic [EW-1:0]      mem [DEPTH];
    logic [EW-1:0]      rd_data_reg;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [EW-1:0]      wr_data;

    logic               accept;
    logic [INDEX_W-1:0] idx;
    logic [LIMIT_W-1:0] top_eff;
    logic [CW-1:0]      top_c;
    logic [EW:0]        trial;
    logic [EW:0]        diff;
    logic               ge;
    logic [EW-1:0]      rem_step;
    logic [EW-1:0]      q_step;
    logic               div_last;
    logic [CW-1:0]      j_sum;
    logic               j_over;
    logic               i_last;
    logic               is_prime;
    logic               out_free;

    assign accept   = s_tvalid && s_tready;
    assign idx      = s_tdata[INDEX_W-1:0];
    assign top_eff  = (limit_reg > LIMIT_W'(TOP_MAX)) ? LIMIT_W'(TOP_MAX) : limit_reg;
    assign top_c    = CW'(built_limit_reg);

    // one restoring divide step: quotient bits shift into dvd_reg
    assign trial    = {rem_reg, dvd_reg[EW-1]};
    assign diff     = trial - {1'b0, i_reg[EW-1:0]};
    assign ge       = trial >= {1'b0, i_reg[EW-1:0]};
    assign rem_step = ge ? diff[EW-1:0] : trial[EW-1:0];
    assign q_step   = {dvd_reg[EW-2:0], ge};
    assign div_last = div_cnt_reg == DW'(EW - 1);

    assign j_sum    = j_reg + i_reg;
    assign j_over   = j_sum > top_c;
    assign i_last   = i_reg == top_c;
    assign is_prime = rd_data_reg == i_reg[EW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_value_reg);
    assign m_tuser  = m_ok_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == KIND_BUILD) ? ST_FILL : ST_RESP;
                end
            end
            ST_FILL:
            begin
                if (j_reg == top_c)
                begin
                    state_next = (top_c < CW'(2)) ? ST_RESP : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (is_prime)
                begin
                    state_next = ST_MUL_RD;
                end
                else
                begin
                    state_next = i_last ? ST_RESP : ST_SCAN_RD;
                end
            end
            ST_MUL_RD:   state_next = ST_MUL_LOAD;
            ST_MUL_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                begin
                    if (j_over)
                    begin
                        state_next = i_last ? ST_RESP : ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_MUL_RD;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        built_next       = built_reg;
        built_limit_next = built_limit_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        t_next           = t_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        div_cnt_next     = div_cnt_reg;
        q_ok_next        = q_ok_reg;
        q_build_next     = q_build_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_value_next     = m_value_reg;
        m_ok_next        = m_ok_reg;
        rd_en            = 1'b0;
        rd_addr          = AW'(i_reg);
        wr_en            = 1'b0;
        wr_addr          = AW'(j_reg);
        wr_data          = EW'(j_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_BUILD)
                    begin
                        built_next       = 1'b1;
                        built_limit_next = top_eff;
                        j_next           = '0;
                        q_build_next     = 1'b1;
                        q_ok_next        = 1'b1;
                    end
                    else
                    begin
                        q_build_next = 1'b0;
                        q_ok_next    = built_reg && (idx <= built_limit_reg);
                        rd_en        = built_reg && (idx <= built_limit_reg);
                        rd_addr      = AW'(idx);
                    end
                end
            end
            ST_FILL:
            begin
                // each entry starts as its own index
                wr_en  = 1'b1;
                j_next = j_reg + CW'(1);
                i_next = CW'(2);
            end
            ST_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            ST_SCAN_CHK:
            begin
                if (is_prime)
                begin
                    j_next = i_reg;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_MUL_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(j_reg);
            end
            ST_MUL_LOAD:
            begin
                t_next       = rd_data_reg;
                dvd_next     = rd_data_reg;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                rem_next     = rem_step;
                dvd_next     = q_step;
                div_cnt_next = div_cnt_reg + DW'(1);
                if (div_last)
                begin
                    // t / i * (i - 1) equals t - t / i for an exact divide
                    wr_en   = 1'b1;
                    wr_data = t_reg - q_step;
                    if (j_over)
                    begin
                        i_next = i_reg + CW'(1);
                    end
                    else
                    begin
                        j_next = j_sum;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_ok_next    = q_ok_reg;
                    if (q_build_reg || !q_ok_reg)
                    begin
                        m_value_next = '0;
                    end
                    else
                    begin
                        m_value_next = VALUE_W'(rd_data_reg);
                    end
                end
            end
            default:
            begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_RESET;
            built_reg       <= 1'b0;
            built_limit_reg <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            div_cnt_reg     <= '0;
            q_ok_reg        <= 1'b0;
            q_build_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            built_reg       <= built_next;
            built_limit_reg <= built_limit_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            div_cnt_reg     <= div_cnt_next;
            q_ok_reg        <= q_ok_next;
            q_build_reg     <= q_build_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        m_value_reg <= m_value_next;
        m_ok_reg    <= m_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `TST_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "beat taken but controller stayed idle")
    `TST_ASSERT_IMPL(a_write_in_range, wr_en, j_reg <= top_c, "table write beyond built limit")
    `TST_ASSERT_IMPL(a_div_operands, state_reg == ST_DIV, i_reg >= CW'(2) && j_reg >= i_reg, "divide with bad prime or multiple")
    `TST_ASSERT_IMPL(a_exact_divide, state_reg == ST_DIV && div_last, rem_step == '0, "sieve divide left a remainder")

endmodule
